FILE: hdl/vpl_pkg.sv
// ----------------------------------------------------------------------------
// vpl_pkg
// shared types and constants for the video port, video memory and line
// interrupt block
// ----------------------------------------------------------------------------
package vpl_pkg;

  // host address space of the access address register
  localparam int AddrW    = 14;
  localparam int AddrSpan = 16384;

  // kind of one input transaction
  typedef enum logic [2:0] {
    KindDataRd   = 3'd0,
    KindDataWr   = 3'd1,
    KindStatusRd = 3'd2,
    KindCtrlWr   = 3'd3,
    KindLineRd   = 3'd4,
    KindLineTick = 3'd5
  } kind_e;

  // access codes carried in the second control byte
  localparam logic [1:0] CodeVramRd = 2'd0;
  localparam logic [1:0] CodeVramWr = 2'd1;
  localparam logic [1:0] CodeRegWr  = 2'd2;
  localparam logic [1:0] CodeCramWr = 2'd3;

  // register indexes that the host side uses
  localparam logic [3:0] RegMode1   = 4'd0;
  localparam logic [3:0] RegMode2   = 4'd1;
  localparam logic [3:0] RegLineCnt = 4'd10;

  // bit positions of the interrupt enables
  localparam int LineIrqEnBit  = 4;
  localparam int FrameIrqEnBit = 5;

  // low bits of the status byte
  localparam logic [4:0] StatusOnes = 5'h1F;

  // value of the line down-counter after reset
  localparam logic [7:0] LineCntReset = 8'hFF;

  // video memory request
  typedef struct packed {
    logic             re;
    logic             we;
    logic [AddrW-1:0] addr;
    logic [7:0]       wdata;
  } vram_req_t;

endpackage

FILE: hdl/vpl_vram.sv
// ----------------------------------------------------------------------------
// vpl_vram
// single port video memory with registered read data and a clearing sweep
// after reset, one entry a cycle
// ----------------------------------------------------------------------------
module vpl_vram #(
  parameter int Depth = 16384
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vpl_pkg::vram_req_t req_i,
  output logic [7:0]        rd_data_o,
  output logic              busy_o
);

  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

  logic [7:0]    mem [Depth];
  logic [7:0]    rd_data_q;
  logic          clr_busy_q, clr_busy_d;
  logic [Aw-1:0] clr_cnt_q, clr_cnt_d;
  logic [Aw-1:0] idx;

  assign idx = req_i.addr[Aw-1:0];

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + Aw'(1);
      if (clr_cnt_q == Aw'(Depth - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_cnt_q] <= 8'h00;
    end else if (req_i.we) begin
      mem[idx] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem[idx];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_busy_q;

endmodule

FILE: hdl/video_port_vram_line_irq.sv
// ----------------------------------------------------------------------------
// video_port_vram_line_irq
// host side of a tile video display processor: data and control ports,
// status and line reads, line down-counter with line and frame interrupts
// ----------------------------------------------------------------------------
// output register holds each result; throughput: one transaction per cycle
// while s_axis_tready is high, at most one video memory access per item
// prefetched bytes come from the memory's registered read port or, after a
// data write, the written byte; reset: asynchronous, active low; after
// release the video memory is swept to zero with s_axis_tready low
// ----------------------------------------------------------------------------
module video_port_vram_line_irq #(
  parameter int VIDEO_MEM_DEPTH = 16384,
  parameter int ACTIVE_LINES    = 192,
  parameter int TOTAL_LINES     = 262
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // wdata[7:0], sprite_overflow_in[8],
                                      // sprite_collision_in[9], zero[15:10]
  input  logic [2:0]  s_axis_tuser,   // kind[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // rdata[7:0], irq_line[8],
                                      // irq_frame[9], zero[15:10]
);

  localparam int Aw   = vpl_pkg::AddrW;
  localparam int NumQ = (vpl_pkg::AddrSpan + VIDEO_MEM_DEPTH - 1) / VIDEO_MEM_DEPTH;

  // address modulo the memory depth: quotient is small, so compare against
  // each multiple of the depth in parallel
  function automatic logic [Aw-1:0] vram_index(input logic [Aw-1:0] a);
    logic [Aw-1:0] r;
    r = a;
    for (int k = 1; k < NumQ; k++) begin
      if ({1'b0, a} >= (Aw+1)'(k * VIDEO_MEM_DEPTH)) begin
        r = a - Aw'(k * VIDEO_MEM_DEPTH);
      end
    end
    return r;
  endfunction

  vpl_pkg::kind_e     kind;
  vpl_pkg::vram_req_t vram_req;
  logic [7:0]         vram_rd;
  logic               vram_busy;
  logic               in_fire;
  logic [7:0]         wdata;
  logic               spr_ovf;
  logic               spr_col;
  logic [Aw-1:0]      new_addr;
  logic [7:0]         pf_val;
  logic [8:0]         ln_inc;

  logic [Aw-1:0] addr_q, addr_d;
  logic [1:0]    code_q, code_d;
  logic [7:0]    prefetch_q, prefetch_d;
  logic          pf_mem_q, pf_mem_d;
  logic [7:0]    latch_q, latch_d;
  logic          expect_first_q, expect_first_d;
  logic [8:0]    line_q, line_d;
  logic [7:0]    down_cnt_q, down_cnt_d;
  logic [2:0]    flags_q, flags_d;
  logic          line_irq_en_q, line_irq_en_d;
  logic          frame_irq_en_q, frame_irq_en_d;
  logic [7:0]    reload_q, reload_d;

  logic          out_valid_q, out_valid_d;
  logic [7:0]    rdata_q, rdata_d;
  logic          irq_line_q, irq_line_d;
  logic          irq_frame_q, irq_frame_d;

  assign kind     = vpl_pkg::kind_e'(s_axis_tuser);
  assign wdata    = s_axis_tdata[7:0];
  assign spr_ovf  = s_axis_tdata[8];
  assign spr_col  = s_axis_tdata[9];
  assign new_addr = {wdata[5:0], latch_q};
  assign pf_val   = pf_mem_q ? vram_rd : prefetch_q;
  assign ln_inc   = line_q + 9'd1;

  assign s_axis_tready = !vram_busy && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    addr_d         = addr_q;
    code_d         = code_q;
    prefetch_d     = prefetch_q;
    pf_mem_d       = pf_mem_q;
    latch_d        = latch_q;
    expect_first_d = expect_first_q;
    line_d         = line_q;
    down_cnt_d     = down_cnt_q;
    flags_d        = flags_q;
    line_irq_en_d  = line_irq_en_q;
    frame_irq_en_d = frame_irq_en_q;
    reload_d       = reload_q;
    rdata_d        = 8'h00;
    irq_line_d     = 1'b0;
    irq_frame_d    = 1'b0;
    vram_req.re    = 1'b0;
    vram_req.we    = 1'b0;
    vram_req.addr  = vram_index(addr_q);
    vram_req.wdata = wdata;

    if (in_fire) begin
      unique case (kind)
        vpl_pkg::KindDataRd: begin
          rdata_d     = pf_val;
          vram_req.re = 1'b1;
          pf_mem_d    = 1'b1;
          addr_d      = addr_q + Aw'(1);
        end
        vpl_pkg::KindDataWr: begin
          // colour memory writes do not reach the video memory
          vram_req.we = (code_q != vpl_pkg::CodeCramWr);
          addr_d      = addr_q + Aw'(1);
          prefetch_d  = wdata;
          pf_mem_d    = 1'b0;
        end
        vpl_pkg::KindStatusRd: begin
          rdata_d        = {flags_q, vpl_pkg::StatusOnes};
          flags_d        = 3'b000;
          expect_first_d = 1'b1;
        end
        vpl_pkg::KindCtrlWr: begin
          if (expect_first_q) begin
            latch_d        = wdata;
            expect_first_d = 1'b0;
          end else begin
            expect_first_d = 1'b1;
            code_d         = wdata[7:6];
            addr_d         = new_addr;
            if (wdata[7:6] == vpl_pkg::CodeVramRd) begin
              vram_req.re   = 1'b1;
              vram_req.addr = vram_index(new_addr);
              pf_mem_d      = 1'b1;
              addr_d        = new_addr + Aw'(1);
            end else if (wdata[7:6] == vpl_pkg::CodeRegWr) begin
              if (wdata[3:0] == vpl_pkg::RegMode1) begin
                line_irq_en_d = latch_q[vpl_pkg::LineIrqEnBit];
              end
              if (wdata[3:0] == vpl_pkg::RegMode2) begin
                frame_irq_en_d = latch_q[vpl_pkg::FrameIrqEnBit];
              end
              if (wdata[3:0] == vpl_pkg::RegLineCnt) begin
                reload_d = latch_q;
              end
            end
          end
        end
        vpl_pkg::KindLineRd: begin
          rdata_d = line_q[7:0];
        end
        vpl_pkg::KindLineTick: begin
          if (line_q < 9'(ACTIVE_LINES)) begin
            flags_d = flags_q | {1'b0, spr_ovf, spr_col};
          end
          if (line_q <= 9'(ACTIVE_LINES)) begin
            down_cnt_d = down_cnt_q - 8'd1;
            if (down_cnt_q == 8'd0) begin
              down_cnt_d = reload_q;
              irq_line_d = line_irq_en_q;
            end
          end else begin
            down_cnt_d = reload_q;
          end
          if (line_q == 9'(ACTIVE_LINES)) begin
            flags_d[2]  = 1'b1;
            irq_frame_d = frame_irq_en_q;
          end
          line_d = (ln_inc >= 9'(TOTAL_LINES)) ? 9'd0 : ln_inc;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_d = in_fire || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q         <= '0;
      code_q         <= vpl_pkg::CodeVramRd;
      prefetch_q     <= 8'h00;
      pf_mem_q       <= 1'b0;
      latch_q        <= 8'h00;
      expect_first_q <= 1'b1;
      line_q         <= 9'd0;
      down_cnt_q     <= vpl_pkg::LineCntReset;
      flags_q        <= 3'b000;
      line_irq_en_q  <= 1'b0;
      frame_irq_en_q <= 1'b0;
      reload_q       <= 8'h00;
      out_valid_q    <= 1'b0;
    end else begin
      addr_q         <= addr_d;
      code_q         <= code_d;
      prefetch_q     <= prefetch_d;
      pf_mem_q       <= pf_mem_d;
      latch_q        <= latch_d;
      expect_first_q <= expect_first_d;
      line_q         <= line_d;
      down_cnt_q     <= down_cnt_d;
      flags_q        <= flags_d;
      line_irq_en_q  <= line_irq_en_d;
      frame_irq_en_q <= frame_irq_en_d;
      reload_q       <= reload_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rdata_q     <= rdata_d;
      irq_line_q  <= irq_line_d;
      irq_frame_q <= irq_frame_d;
    end
  end

  vpl_vram #(
    .Depth (VIDEO_MEM_DEPTH)
  ) u_vram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (vram_req),
    .rd_data_o (vram_rd),
    .busy_o    (vram_busy)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b000000, irq_frame_q, irq_line_q, rdata_q};

endmodule

FILE: hdl/vpl_checker.sv
// ----------------------------------------------------------------------------
// vpl_checker
// port level checks on the video port block, bound to the top level
// ----------------------------------------------------------------------------
module vpl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn under stall");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed under stall");

  // a fresh result only follows an input transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result without input transaction");

  // a taken result with no new input leaves the output empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !(s_axis_tvalid && s_axis_tready)
    |=> !m_axis_tvalid)
    else $error("result repeated");

endmodule

bind video_port_vram_line_irq vpl_checker u_vpl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
